[rtl/wrc_pkg.sv]
`timescale 1ns / 1ps
package wrc_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int FILE_W   = 16;
    localparam int PAGE_W   = 32;
    localparam int CNT_W    = 9;
    localparam int ADR48_W  = 48;
    localparam int LEN_W    = 32;
    localparam int PGB_W    = 17;
    localparam int SEGS_W   = 11;
    localparam int REQS_W   = 6;
    localparam int QCNT_W   = 6;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [PGB_W-1:0]  PAGE_BYTES_RST = PGB_W'(8192);
    localparam logic [SEGS_W-1:0] MAX_SEGS_RST   = SEGS_W'(16);

    typedef enum logic [1:0] {
        REQ_ENQ   = 2'd0,
        REQ_FLUSH = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_RSVD  = 2'd3
    } t_req_type;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_ACK   = 1'b1
    } t_kind;

    typedef enum logic {
        REG_PAGE_BYTES = 1'b0,
        REG_MAX_SEGS   = 1'b1
    } t_reg_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC,
        S_WALK_RD,
        S_WALK_EV,
        S_WALK_END,
        S_INS_START,
        S_INS_RD,
        S_INS_SH,
        S_INS_PUT,
        S_ACK
    } t_state;

    typedef struct packed {
        logic [FILE_W-1:0]  file;
        logic [ADR48_W-1:0] offset;
        logic [LEN_W-1:0]   length;
        logic [ADR48_W-1:0] buffer;
    } t_entry;

    typedef struct packed {
        logic latch_in;
        logic calc;
        logic walk_init;
        logic walk_rd;
        logic walk_step;
        logic walk_end;
        logic ins_init;
        logic ins_rd;
        logic ins_shift;
        logic ins_put;
        logic ack_emit;
    } t_cmd;

    typedef struct packed {
        logic              is_enq;
        logic              is_flush;
        logic              fill_zero;
        logic              full;
        logic              ahead;
        logic              j_is_one;
        logic              need_emit;
        logic              group_open;
        logic              k_last;
        logic              out_free;
        logic [FILL_W-1:0] fill;
    } t_status;

endpackage

[rtl/wrc_if.sv]
`timescale 1ns / 1ps
interface wrc_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     req_type;
    logic [wrc_pkg::FILE_W-1:0]     file_id;
    logic [wrc_pkg::PAGE_W-1:0]     start_page;
    logic [wrc_pkg::CNT_W-1:0]      page_count;
    logic [wrc_pkg::ADR48_W-1:0]    buffer_address;

    modport source (output valid, req_type, file_id, start_page, page_count,
                    buffer_address, input ready);
    modport sink (input valid, req_type, file_id, start_page, page_count,
                  buffer_address, output ready);
endinterface

interface wrc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [wrc_pkg::FILE_W-1:0]     write_file;
    logic [wrc_pkg::ADR48_W-1:0]    write_offset;
    logic [wrc_pkg::LEN_W-1:0]      write_bytes;
    logic [wrc_pkg::SEGS_W-1:0]     segment_count;
    logic [wrc_pkg::REQS_W-1:0]     request_count;
    logic [wrc_pkg::QCNT_W-1:0]     queued_count;
    logic                           last;

    modport source (output valid, kind, write_file, write_offset, write_bytes,
                    segment_count, request_count, queued_count, last, input ready);
    modport sink (input valid, kind, write_file, write_offset, write_bytes,
                  segment_count, request_count, queued_count, last, output ready);
endinterface

[rtl/wrc_ctrl.sv]
`timescale 1ns / 1ps
module wrc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  wrc_pkg::t_status i_status,
    output logic             o_in_ready,
    output wrc_pkg::t_cmd    o_cmd
);
    import wrc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                if (i_status.is_enq) begin
                    if (i_status.full) begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = S_WALK_RD;
                    end else begin
                        n_state = S_INS_START;
                    end
                end else if (i_status.is_flush) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = i_status.fill_zero ? S_WALK_END : S_WALK_RD;
                end else begin
                    n_state = S_ACK;
                end
            end
            S_WALK_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = S_WALK_EV;
            end
            S_WALK_EV: begin
                // hold while a closed group cannot be handed to the output
                if (!(i_status.need_emit && !i_status.out_free)) begin
                    o_cmd.walk_step = 1'b1;
                    n_state = i_status.k_last ? S_WALK_END : S_WALK_RD;
                end
            end
            S_WALK_END: begin
                if (!(i_status.group_open && !i_status.out_free)) begin
                    o_cmd.walk_end = 1'b1;
                    n_state = i_status.is_enq ? S_INS_START : S_ACK;
                end
            end
            S_INS_START: begin
                o_cmd.ins_init = 1'b1;
                n_state = i_status.fill_zero ? S_INS_PUT : S_INS_RD;
            end
            S_INS_RD: begin
                o_cmd.ins_rd = 1'b1;
                n_state      = S_INS_SH;
            end
            S_INS_SH: begin
                if (i_status.ahead) begin
                    o_cmd.ins_shift = 1'b1;
                    if (i_status.j_is_one) begin
                        n_state = S_INS_PUT;
                    end
                end else begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = S_ACK;
                end
            end
            S_INS_PUT: begin
                o_cmd.ins_put = 1'b1;
                n_state       = S_ACK;
            end
            S_ACK: begin
                if (i_status.out_free) begin
                    o_cmd.ack_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/wrc_datapath.sv]
`timescale 1ns / 1ps
module wrc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wrc_pkg::t_cmd                 i_cmd,
    output wrc_pkg::t_status              o_status,
    wrc_in_if.sink                        i_req,
    wrc_out_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wrc_pkg::PADDR_W-1:0]   paddr,
    input  logic [wrc_pkg::PDATA_W-1:0]   pwdata,
    output logic [wrc_pkg::PDATA_W-1:0]   prdata
);
    import wrc_pkg::*;

    logic [PGB_W-1:0]   r_page_bytes;
    logic [SEGS_W-1:0]  r_max_segs;

    logic [1:0]         r_type;
    logic [FILE_W-1:0]  r_file;
    logic [PAGE_W-1:0]  r_page;
    logic [CNT_W-1:0]   r_cnt;
    logic [ADR48_W-1:0] r_buf;
    logic [ADR48_W-1:0] r_off;
    logic [LEN_W-1:0]   r_len;
    logic [QCNT_W-1:0]  r_final;

    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rd;
    logic [FILL_W-1:0]  r_fill;
    logic [ADDR_W-1:0]  r_j;
    logic [ADDR_W-1:0]  r_k;

    logic               r_gopen;
    logic [FILE_W-1:0]  r_gfile;
    logic [ADR48_W-1:0] r_gstart;
    logic [ADR48_W-1:0] r_next;
    logic [ADR48_W-1:0] r_segend;
    logic [SEGS_W-1:0]  r_segs;
    logic [LEN_W-1:0]   r_total;
    logic [REQS_W-1:0]  r_reqs;

    logic               r_ovalid;
    logic               r_okind;
    logic [FILE_W-1:0]  r_ofile;
    logic [ADR48_W-1:0] r_ooff;
    logic [LEN_W-1:0]   r_obytes;
    logic [SEGS_W-1:0]  r_osegs;
    logic [REQS_W-1:0]  r_oreqs;
    logic [QCNT_W-1:0]  r_oqueued;
    logic               r_olast;

    t_entry             w_new;
    logic [48:0]        w_off_prod;
    logic [25:0]        w_len_prod;
    logic [SEGS_W-1:0]  w_lim;
    logic               w_contig;
    logic               w_joins;
    logic               w_need_emit;
    logic               w_out_free;
    logic               w_emit_group;
    logic               w_mem_we;
    logic [ADDR_W-1:0]  w_mem_wa;
    t_entry             w_mem_wd;
    logic               w_rd_en;
    logic [ADDR_W-1:0]  w_rd_a;
    t_req_type          w_type;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= PAGE_BYTES_RST;
            r_max_segs   <= MAX_SEGS_RST;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_sel'(paddr[2]))
                REG_PAGE_BYTES: r_page_bytes <= pwdata[PGB_W-1:0];
                REG_MAX_SEGS:   r_max_segs   <= pwdata[SEGS_W-1:0];
                default:        r_max_segs   <= r_max_segs;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_sel'(paddr[2]))
            REG_PAGE_BYTES: prdata = PDATA_W'(r_page_bytes);
            REG_MAX_SEGS:   prdata = PDATA_W'(r_max_segs);
            default:        prdata = '0;
        endcase
    end

    assign w_type     = t_req_type'(r_type);
    assign w_off_prod = 49'(r_page) * 49'(r_page_bytes);
    assign w_len_prod = 26'(r_cnt) * 26'(r_page_bytes);
    assign w_new      = '{file: r_file, offset: r_off, length: r_len, buffer: r_buf};

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_type <= i_req.req_type;
            r_file <= i_req.file_id;
            r_page <= i_req.start_page;
            r_cnt  <= i_req.page_count;
            r_buf  <= i_req.buffer_address;
        end
        if (i_cmd.calc) begin
            r_off <= w_off_prod[ADR48_W-1:0];
            r_len <= LEN_W'(w_len_prod);
            case (w_type)
                REQ_ENQ:   r_final <= (r_fill == FILL_W'(QUEUE_DEPTH)) ? QCNT_W'(1)
                                      : QCNT_W'(r_fill + FILL_W'(1));
                REQ_FLUSH: r_final <= '0;
                default:   r_final <= QCNT_W'(r_fill);
            endcase
        end
    end

    // queue memory: one write and one registered read per cycle
    always_comb begin
        w_mem_we = i_cmd.ins_shift || i_cmd.ins_put;
        w_mem_wa = r_j;
        w_mem_wd = i_cmd.ins_shift ? r_rd : w_new;
        w_rd_en  = i_cmd.walk_rd || i_cmd.ins_rd || i_cmd.ins_shift;
        if (i_cmd.walk_rd) begin
            w_rd_a = r_k;
        end else if (i_cmd.ins_rd) begin
            w_rd_a = r_j - ADDR_W'(1);
        end else begin
            w_rd_a = r_j - ADDR_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.walk_end) begin
            r_fill <= '0;
        end else if (i_cmd.ins_put) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_init) begin
            r_j <= r_fill[ADDR_W-1:0];
        end else if (i_cmd.ins_shift) begin
            r_j <= r_j - ADDR_W'(1);
        end
    end

    // group walk over the sorted queue
    assign w_lim       = (r_max_segs == '0) ? SEGS_W'(1) : r_max_segs;
    assign w_contig    = (r_segend == r_rd.buffer);
    assign w_joins     = r_gopen && (r_rd.file == r_gfile) && (r_rd.offset == r_next)
                         && (w_contig || (r_segs < w_lim));
    assign w_need_emit = r_gopen && !w_joins;
    assign w_out_free  = !r_ovalid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gopen <= 1'b0;
        end else if (i_cmd.walk_init || i_cmd.walk_end) begin
            r_gopen <= 1'b0;
        end else if (i_cmd.walk_step) begin
            r_gopen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_k <= '0;
        end else if (i_cmd.walk_step) begin
            r_k <= r_k + ADDR_W'(1);
            if (w_joins) begin
                r_next  <= r_next + ADR48_W'(r_rd.length);
                r_total <= r_total + r_rd.length;
                r_reqs  <= r_reqs + REQS_W'(1);
                if (w_contig) begin
                    r_segend <= r_segend + ADR48_W'(r_rd.length);
                end else begin
                    r_segs   <= r_segs + SEGS_W'(1);
                    r_segend <= r_rd.buffer + ADR48_W'(r_rd.length);
                end
            end else begin
                r_gfile  <= r_rd.file;
                r_gstart <= r_rd.offset;
                r_next   <= r_rd.offset + ADR48_W'(r_rd.length);
                r_segend <= r_rd.buffer + ADR48_W'(r_rd.length);
                r_segs   <= SEGS_W'(1);
                r_total  <= r_rd.length;
                r_reqs   <= REQS_W'(1);
            end
        end
    end

    // output register
    assign w_emit_group = (i_cmd.walk_step && w_need_emit) || (i_cmd.walk_end && r_gopen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit_group || i_cmd.ack_emit) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_group) begin
            r_okind   <= KIND_WRITE;
            r_ofile   <= r_gfile;
            r_ooff    <= r_gstart;
            r_obytes  <= r_total;
            r_osegs   <= r_segs;
            r_oreqs   <= r_reqs;
            r_oqueued <= r_final;
            r_olast   <= 1'b0;
        end else if (i_cmd.ack_emit) begin
            r_okind   <= KIND_ACK;
            r_ofile   <= '0;
            r_ooff    <= '0;
            r_obytes  <= '0;
            r_osegs   <= '0;
            r_oreqs   <= '0;
            r_oqueued <= r_final;
            r_olast   <= 1'b1;
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.kind          = r_okind;
    assign o_rsp.write_file    = r_ofile;
    assign o_rsp.write_offset  = r_ooff;
    assign o_rsp.write_bytes   = r_obytes;
    assign o_rsp.segment_count = r_osegs;
    assign o_rsp.request_count = r_oreqs;
    assign o_rsp.queued_count  = r_oqueued;
    assign o_rsp.last          = r_olast;

    always_comb begin
        o_status            = '0;
        o_status.is_enq     = (w_type == REQ_ENQ);
        o_status.is_flush   = (w_type == REQ_FLUSH);
        o_status.fill_zero  = (r_fill == '0);
        o_status.full       = (r_fill == FILL_W'(QUEUE_DEPTH));
        o_status.ahead      = (r_file < r_rd.file)
                              || ((r_file == r_rd.file) && (r_off < r_rd.offset));
        o_status.j_is_one   = (r_j == ADDR_W'(1));
        o_status.need_emit  = w_need_emit;
        o_status.group_open = r_gopen;
        o_status.k_last     = ({1'b0, r_k} == (r_fill - FILL_W'(1)));
        o_status.out_free   = w_out_free;
        o_status.fill       = r_fill;
    end

endmodule

[rtl/write_request_coalescer_top.sv]
`timescale 1ns / 1ps
// Write request coalescer.
// i_req carries one request per beat: enqueue, force flush or query. o_rsp
// returns the write commands of a flush, one per group of same-file,
// contiguous requests of at most max_segments buffer segments, followed
// by one acknowledge beat with last set. The queue is kept sorted by
// file and byte offset as requests come in. A query goes straight to the
// acknowledge. An enqueue shifts each queued entry that sorts after the
// new one (insertion shift through the queue memory), then stores it.
// A flush walks each queued entry (registered memory read, then group
// update). An enqueue into a full queue runs the flush first.
// One request is handled at a time; i_req.ready is high only while idle.
// When o_rsp stalls, the walk holds until the output register frees up.
// Reset empties the queue and loads page_bytes = 8192, max_segments = 16;
// queue memory contents need no clearing.
// Configuration: APB at byte address 0 (page_bytes) and 4 (max_segments).
// It is to be written only while idle; the block does not enforce this.
module write_request_coalescer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wrc_in_if.sink                        i_req,
    wrc_out_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wrc_pkg::PADDR_W-1:0]   paddr,
    input  logic [wrc_pkg::PDATA_W-1:0]   pwdata,
    output logic [wrc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import wrc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign pready      = 1'b1;
    assign i_req.ready = w_in_ready;

    wrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    wrc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

    a_last_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.last) |-> (o_rsp.kind == KIND_ACK))
        else $error("last beat is not an acknowledge");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.fill <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");

    a_cmd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind == KIND_WRITE)
            |-> (o_rsp.request_count != '0 && o_rsp.segment_count != '0))
        else $error("empty write command");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import wrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam logic [PADDR_W-1:0] ADDR_PAGE_BYTES = PADDR_W'(4 * REG_PAGE_BYTES);
    localparam logic [PADDR_W-1:0] ADDR_MAX_SEGS   = PADDR_W'(4 * REG_MAX_SEGS);

    typedef struct {
        logic               kind;
        logic [FILE_W-1:0]  file;
        logic [ADR48_W-1:0] offset;
        logic [LEN_W-1:0]   nbytes;
        logic [SEGS_W-1:0]  segs;
        logic [REQS_W-1:0]  reqs;
        logic [QCNT_W-1:0]  queued;
        logic               last;
    } t_rsp_beat;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    wrc_in_if  req_if();
    wrc_out_if rsp_if();

    write_request_coalescer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the queue and registers
    logic [FILE_W-1:0]  q_file [QUEUE_DEPTH];
    logic [ADR48_W-1:0] q_off  [QUEUE_DEPTH];
    logic [LEN_W-1:0]   q_len  [QUEUE_DEPTH];
    logic [ADR48_W-1:0] q_buf  [QUEUE_DEPTH];
    int                 q_fill;
    logic               q_unsorted;
    logic [PGB_W-1:0]   cfg_page_bytes;
    logic [SEGS_W-1:0]  cfg_max_segs;

    t_rsp_beat pending_beats[$];
    int        error_count;
    int        idle_cycles;
    bit        no_idle;
    int        stall_left;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit sorts_first(logic [FILE_W-1:0] fa, logic [ADR48_W-1:0] oa,
                                       logic [FILE_W-1:0] fb, logic [ADR48_W-1:0] ob);
        return fa < fb || (fa == fb && oa < ob);
    endfunction

    function automatic void push_cmd(logic [FILE_W-1:0] f, logic [ADR48_W-1:0] o,
                                     logic [LEN_W-1:0] n, int segs, int reqs);
        t_rsp_beat b;
        b.kind   = KIND_WRITE;
        b.file   = f;
        b.offset = o;
        b.nbytes = n;
        b.segs   = SEGS_W'(segs);
        b.reqs   = REQS_W'(reqs);
        b.queued = '0;
        b.last   = 1'b0;
        pending_beats.push_back(b);
    endfunction

    function automatic void coalesce_queue();
        int lim, k, first, segs, j;
        logic [FILE_W-1:0]  f;
        logic [ADR48_W-1:0] start, nxt, base;
        logic [63:0]        seg_len;
        logic [LEN_W-1:0]   total;
        logic [FILE_W-1:0]  tf;
        logic [ADR48_W-1:0] to, tb;
        logic [LEN_W-1:0]   tl;
        lim = (cfg_max_segs == 0) ? 1 : int'(cfg_max_segs);
        // stable insertion sort by file, then offset
        for (int i = 1; i < q_fill; i++) begin
            tf = q_file[i]; to = q_off[i]; tl = q_len[i]; tb = q_buf[i];
            j = i;
            while (j > 0 && sorts_first(tf, to, q_file[j-1], q_off[j-1])) begin
                q_file[j] = q_file[j-1]; q_off[j] = q_off[j-1];
                q_len[j] = q_len[j-1]; q_buf[j] = q_buf[j-1];
                j--;
            end
            q_file[j] = tf; q_off[j] = to; q_len[j] = tl; q_buf[j] = tb;
        end
        q_unsorted = 1'b0;
        k = 0;
        while (k < q_fill) begin
            first = k;
            f = q_file[k];
            start = q_off[k];
            nxt = start;
            base = q_buf[k];
            seg_len = 0;
            segs = 1;
            total = '0;
            do begin
                if (ADR48_W'(base + seg_len) == q_buf[k]) begin
                    seg_len += q_len[k];
                end else if (segs < lim) begin
                    segs++;
                    base = q_buf[k];
                    seg_len = q_len[k];
                end else begin
                    break;
                end
                nxt = nxt + q_len[k];
                total = total + q_len[k];
                k++;
            end while (k < q_fill && q_file[k] == f && q_off[k] == nxt);
            push_cmd(f, start, total, segs, k - first);
        end
        q_fill = 0;
    endfunction

    function automatic void predict_request(t_req_type rt, logic [FILE_W-1:0] f,
                                            logic [PAGE_W-1:0] pg, logic [CNT_W-1:0] cnt,
                                            logic [ADR48_W-1:0] bufa);
        int first_new;
        logic [ADR48_W-1:0] off;
        t_rsp_beat ack;
        first_new = pending_beats.size();
        if (rt == REQ_ENQ) begin
            off = ADR48_W'(64'(pg) * 64'(cfg_page_bytes));
            if (q_fill >= QUEUE_DEPTH) coalesce_queue();
            if (q_fill > 0 && sorts_first(f, off, q_file[q_fill-1], q_off[q_fill-1]))
                q_unsorted = 1'b1;
            q_file[q_fill] = f;
            q_off[q_fill]  = off;
            q_len[q_fill]  = LEN_W'(32'(cnt) * 32'(cfg_page_bytes));
            q_buf[q_fill]  = bufa;
            q_fill++;
        end else if (rt == REQ_FLUSH) begin
            coalesce_queue();
        end
        ack = '{KIND_ACK, '0, '0, '0, '0, '0, '0, 1'b1};
        pending_beats.push_back(ack);
        for (int i = first_new; i < pending_beats.size(); i++)
            pending_beats[i].queued = QCNT_W'(q_fill);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // hold valid across back-to-back beats; drop it only for a gap
    task automatic send_request(t_req_type rt, logic [FILE_W-1:0] f, logic [PAGE_W-1:0] pg,
                                logic [CNT_W-1:0] cnt, logic [ADR48_W-1:0] bufa);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.req_type       <= rt;
        req_if.file_id        <= f;
        req_if.start_page     <= pg;
        req_if.page_count     <= cnt;
        req_if.buffer_address <= bufa;
        do @(posedge i_clk); while (!req_if.ready);
        predict_request(rt, f, pg, cnt, bufa);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_beats.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PAGE_BYTES) cfg_page_bytes = PGB_W'(data);
        else cfg_max_segs = SEGS_W'(data);
    endtask

    task automatic set_config(int pgb, int segs);
        wait_drained();
        apb_write(ADDR_PAGE_BYTES, PDATA_W'(pgb));
        apb_write(ADDR_MAX_SEGS, PDATA_W'(segs));
    endtask

    task automatic enq(logic [FILE_W-1:0] f, logic [PAGE_W-1:0] pg, logic [CNT_W-1:0] cnt,
                       logic [ADR48_W-1:0] bufa);
        send_request(REQ_ENQ, f, pg, cnt, bufa);
    endtask

    task automatic ctl(t_req_type rt);
        send_request(rt, FILE_W'($urandom()), $urandom(), CNT_W'($urandom()),
                     ADR48_W'({$urandom(), $urandom()}));
    endtask

    task automatic test_directed_edges();
        ctl(REQ_FLUSH);                                   // empty flush
        ctl(REQ_QUERY);
        ctl(REQ_RSVD);                                    // unused type acts as query
        enq(16'hFFFF, 32'hFFFF_FFFF, 9'd256, 48'hFFFF_FFFF_FFFF);
        enq(16'h0000, 32'h0, 9'd1, 48'h0);
        enq(16'h0000, 32'h1, 9'd0, 48'h2000);             // zero page count
        enq(16'h0000, 32'h1, 9'd511, 48'h2000);
        enq(16'h1234, 32'hFFFF_FFF0, 9'd8, 48'hFFFF_FFFF_F000); // address wrap
        enq(16'h1234, 32'hFFFF_FFF8, 9'd8, 48'h0000_0000_F000);
        ctl(REQ_QUERY);
        ctl(REQ_FLUSH);
        set_config(0, 0);                                 // zero page size, zero limit
        enq(16'h7, 32'h5, 9'd3, 48'h100);
        enq(16'h7, 32'h9, 9'd3, 48'h900);
        enq(16'h7, 32'h5, 9'd3, 48'h300);
        ctl(REQ_FLUSH);
        set_config(65536, 2047);
        // three contiguous 16 MiB requests, one buffer segment
        for (int i = 0; i < 3; i++) enq(16'h42, 32'(i * 256), 9'd256, 48'(64'(i) << 24));
        ctl(REQ_FLUSH);
    endtask

    task automatic test_full_queue();
        set_config(512, 1);
        // reverse order forces the sort; the 33rd enqueue flushes first
        for (int i = QUEUE_DEPTH; i >= 0; i--)
            enq(16'(i % 3), 32'(i * 4), 9'd4, 48'(i * 2048));
        ctl(REQ_FLUSH);
    endtask

    task automatic send_stream(int nfiles);
        logic [FILE_W-1:0]  files [4];
        logic [PAGE_W-1:0]  pg    [4];
        logic [ADR48_W-1:0] bufa  [4];
        logic [CNT_W-1:0]   cnt;
        int n, s, r;
        for (int i = 0; i < nfiles; i++) begin
            files[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
            pg[i]    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000);
            bufa[i]  = ADR48_W'({$urandom, $urandom});
        end
        n = $urandom_range(2, 14);
        for (int i = 0; i < n; i++) begin
            s = $urandom_range(0, nfiles - 1);
            r = $urandom_range(0, 99);
            cnt = CNT_W'($urandom_range(1, 8));
            if (r < 6) cnt = CNT_W'($urandom_range(0, 511));
            if (r >= 90) pg[s] = pg[s] - $urandom_range(1, 30);      // step back
            else if (r >= 82) pg[s] = pg[s] + $urandom_range(1, 10); // hole
            if (r % 5 == 0) bufa[s] = ADR48_W'({$urandom, $urandom}); // new segment
            enq(files[s], pg[s], cnt, bufa[s]);
            pg[s]   = pg[s] + cnt;
            bufa[s] = bufa[s] + 48'(32'(cnt) * 32'(cfg_page_bytes));
        end
    endtask

    task automatic test_random_streams(int target);
        int sent, r;
        int pgb_pick [5] = '{512, 8192, 65536, 4096, 1000};
        int seg_pick [6] = '{1, 2, 3, 16, 1024, 0};
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 3) == 0)
                set_config(pgb_pick[$urandom_range(0, 4)], seg_pick[$urandom_range(0, 5)]);
            no_idle = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_stream($urandom_range(1, 4));
                sent += 8;
            end else begin
                send_request(t_req_type'($urandom_range(0, 3)), FILE_W'($urandom), $urandom,
                             CNT_W'($urandom), ADR48_W'({$urandom, $urandom}));
                sent++;
            end
            r = $urandom_range(0, 9);
            if (r < 6) ctl(REQ_FLUSH);
            else if (r < 8) ctl(REQ_QUERY);
            sent++;
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 9) < 3) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_rsp_beat want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_beats.size() == 0) begin
                $display("MISMATCH unexpected beat at %0t", $realtime);
                error_count++;
            end else begin
                want = pending_beats.pop_front();
                if (rsp_if.kind !== want.kind) report_mismatch("kind", rsp_if.kind, want.kind);
                if (rsp_if.write_file !== want.file)
                    report_mismatch("write_file", rsp_if.write_file, want.file);
                if (rsp_if.write_offset !== want.offset)
                    report_mismatch("write_offset", rsp_if.write_offset, want.offset);
                if (rsp_if.write_bytes !== want.nbytes)
                    report_mismatch("write_bytes", rsp_if.write_bytes, want.nbytes);
                if (rsp_if.segment_count !== want.segs)
                    report_mismatch("segment_count", rsp_if.segment_count, want.segs);
                if (rsp_if.request_count !== want.reqs)
                    report_mismatch("request_count", rsp_if.request_count, want.reqs);
                if (rsp_if.queued_count !== want.queued)
                    report_mismatch("queued_count", rsp_if.queued_count, want.queued);
                if (rsp_if.last !== want.last) report_mismatch("last", rsp_if.last, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (pending_beats.size() > 0 || req_if.valid) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        stall_left = 0;
        q_fill = 0;
        q_unsorted = 1'b0;
        cfg_page_bytes = PAGE_BYTES_RST;
        cfg_max_segs = MAX_SEGS_RST;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rsp_if.ready = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_QUERY;
        req_if.file_id = '0;
        req_if.start_page = '0;
        req_if.page_count = '0;
        req_if.buffer_address = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_full_queue();
        test_random_streams(260);
        wait_drained();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
